>>> rtl/core/ytr_pkg.sv
// ----------------------------------------------------------------------------
// ytr_pkg: shared types and constants for the yuv to argb rotating writer
// widths, register codes, rotation codes and the bt.601 coefficients
// ----------------------------------------------------------------------------
package ytr_pkg;

	// frame geometry limits
	localparam int MAX_DIM    = 4096;
	localparam int MAX_STRIDE = 8192;

	localparam int DIM_W = $clog2(MAX_DIM + 1);     // fitted width / height
	localparam int CNT_W = $clog2(MAX_DIM);         // column / row position
	localparam int STR_W = $clog2(MAX_STRIDE + 1);  // fitted stride
	localparam int PROD_W = CNT_W + STR_W;          // index product

	// register file
	localparam int ROT_W        = 2;
	localparam int WIDTH_REG_W  = 13;
	localparam int HEIGHT_REG_W = 13;
	localparam int STRIDE_REG_W = 14;
	localparam int CFG_DATA_W   = 14;
	localparam int CFG_IDX_W    = 2;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);
	localparam logic [STRIDE_REG_W-1:0] STRIDE_RESET = STRIDE_REG_W'(640);

	// word fields
	localparam int SAMPLE_W = 8;
	localparam int PIXEL_W  = 32;
	localparam int INDEX_W  = 25;

	// bt.601 integer conversion
	localparam int LUMA_OFFSET   = 16;
	localparam int CHROMA_OFFSET = 128;
	localparam int COEF_Y        = 1192;
	localparam int COEF_RV       = 1634;
	localparam int COEF_GV       = 833;
	localparam int COEF_GU       = 400;
	localparam int COEF_BU       = 2066;
	localparam int CLAMP_MAX     = 262143;
	localparam int SUM_W         = 21;
	localparam logic [SAMPLE_W-1:0] ALPHA_OPAQUE = 8'hff;

	typedef enum logic [ROT_W-1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROTATION = 2'd0,
		REG_WIDTH    = 2'd1,
		REG_HEIGHT   = 2'd2,
		REG_STRIDE   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		rot_t                    rotation;
		logic [WIDTH_REG_W-1:0]  width;
		logic [HEIGHT_REG_W-1:0] height;
		logic [STRIDE_REG_W-1:0] stride;
	} ytr_cfg_t;

	// index operands for one pixel: mul_a * stride + add_b
	typedef struct packed {
		logic [CNT_W-1:0] mul_a;
		logic [STR_W-1:0] stride;
		logic [CNT_W-1:0] add_b;
		logic             last;
	} ytr_pos_t;

endpackage

>>> rtl/core/ytr_in_if.sv
// ----------------------------------------------------------------------------
// ytr_in_if: source pixel channel
// valid/ready handshake carrying one yuv sample triple per word
// ----------------------------------------------------------------------------
interface ytr_in_if
	import ytr_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] luma;
	logic [SAMPLE_W-1:0] chroma_blue;
	logic [SAMPLE_W-1:0] chroma_red;

	modport source (output valid, output luma, output chroma_blue, output chroma_red,
		input ready);
	modport sink (input valid, input luma, input chroma_blue, input chroma_red,
		output ready);
endinterface

>>> rtl/core/ytr_out_if.sv
// ----------------------------------------------------------------------------
// ytr_out_if: destination pixel channel
// valid/ready handshake carrying an argb word, its word index and frame end
// ----------------------------------------------------------------------------
interface ytr_out_if
	import ytr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel_word;
	logic [INDEX_W-1:0] dest_index;
	logic               frame_end;

	modport source (output valid, output pixel_word, output dest_index, output frame_end,
		input ready);
	modport sink (input valid, input pixel_word, input dest_index, input frame_end,
		output ready);
endinterface

>>> rtl/core/yuv_to_rgba_rotating_writer_top.sv
// a word is registered in stage 1, then in stage 2, which drives pixel_out
// throughput: one word per cycle unless stalled; the index multiply and color sums are one stage
// backpressure: pixel_in.ready falls only while both stages hold words
// reset: arst_n clears the stage valids and the column/row counters, and
// loads the registers with rotation 0, 640 x 480, stride 640
// ----------------------------------------------------------------------------
// yuv_to_rgba_rotating_writer_top: yuv pixel stream to rotated argb writes
// two-stage pipeline: position and operand capture, then index and color
// ----------------------------------------------------------------------------
module yuv_to_rgba_rotating_writer_top
	import ytr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ytr_in_if.sink                pixel_in,
	ytr_out_if.source             pixel_out
);

	// configuration registers
	ytr_cfg_t cfg_q;

	// stage control
	logic adv_s1;
	logic adv_s2;
	logic accept;

	// stage 1: samples and index operands
	logic                valid_s1;
	logic [SAMPLE_W-1:0] luma_s1;
	logic [SAMPLE_W-1:0] chroma_blue_s1;
	logic [SAMPLE_W-1:0] chroma_red_s1;
	ytr_pos_t            pos_s1;

	// stage 2: finished output word
	logic               valid_s2;
	logic [PIXEL_W-1:0] pixel_s2;
	logic [INDEX_W-1:0] index_s2;
	logic               last_s2;

	// combinational results
	ytr_pos_t           pos_next;
	logic [PIXEL_W-1:0] pixel_next;
	logic [PROD_W-1:0]  idx_prod;
	logic [PROD_W:0]    idx_sum;
	logic [INDEX_W-1:0] index_next;

	// ------------------------------------------------------------------
	// register writes, masked to width by the port slices
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotation <= ROT_0;
			cfg_q.width    <= WIDTH_RESET;
			cfg_q.height   <= HEIGHT_RESET;
			cfg_q.stride   <= STRIDE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROTATION: cfg_q.rotation <= rot_t'(cfg_data[ROT_W-1:0]);
				REG_WIDTH:    cfg_q.width    <= cfg_data[WIDTH_REG_W-1:0];
				REG_HEIGHT:   cfg_q.height   <= cfg_data[HEIGHT_REG_W-1:0];
				REG_STRIDE:   cfg_q.stride   <= cfg_data[STRIDE_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// handshake: each stage moves when the one after it has room
	// ------------------------------------------------------------------
	assign adv_s2         = !valid_s2 || pixel_out.ready;
	assign adv_s1         = !valid_s1 || adv_s2;
	assign pixel_in.ready = adv_s1;
	assign accept         = pixel_in.valid && adv_s1;

	// position counters step once per accepted word
	ytr_pos u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (accept),
		.pos    (pos_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= pixel_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			luma_s1        <= pixel_in.luma;
			chroma_blue_s1 <= pixel_in.chroma_blue;
			chroma_red_s1  <= pixel_in.chroma_red;
			pos_s1         <= pos_next;
		end
	end

	// ------------------------------------------------------------------
	// stage 2 logic: one multiply-add for the index, constant sums for color
	// ------------------------------------------------------------------
	assign idx_prod   = PROD_W'(pos_s1.mul_a) * PROD_W'(pos_s1.stride);
	assign idx_sum    = (PROD_W+1)'(idx_prod) + (PROD_W+1)'(pos_s1.add_b);
	// index wraps at the 25-bit word offset
	assign index_next = INDEX_W'(idx_sum);

	ytr_csc u_csc (
		.luma        (luma_s1),
		.chroma_blue (chroma_blue_s1),
		.chroma_red  (chroma_red_s1),
		.pixel_word  (pixel_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pixel_s2 <= pixel_next;
			index_s2 <= index_next;
			last_s2  <= pos_s1.last;
		end
	end

	assign pixel_out.valid      = valid_s2;
	assign pixel_out.pixel_word = pixel_s2;
	assign pixel_out.dest_index = index_s2;
	assign pixel_out.frame_end  = last_s2;

`ifndef SYNTHESIS
	// every delivered word is opaque
	a_alpha_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_out.valid |-> (pixel_out.pixel_word[PIXEL_W-1:PIXEL_W-SAMPLE_W] == ALPHA_OPAQUE))
		else $error("output word without opaque alpha");

	// a word in stage 1 moves into an empty stage 2
	a_bubble_fill: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> valid_s2)
		else $error("stage 2 did not take the stage 1 word");

	// a stalled stage 1 word is kept, not dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(pos_s1))
		else $error("stage 1 word lost under stall");

	// no word is taken while both stages are full and the sink stalls
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !pixel_out.ready |-> !pixel_in.ready)
		else $error("input accepted with a full pipeline");
`endif

endmodule

>>> rtl/core/ytr_pos.sv
// ----------------------------------------------------------------------------
// ytr_pos: source position tracking
// column/row counters and selection of the rotation index operands
// ----------------------------------------------------------------------------
module ytr_pos
	import ytr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  ytr_cfg_t cfg,
	input  logic     step,
	output ytr_pos_t pos
);

	logic [CNT_W-1:0] column_q;
	logic [CNT_W-1:0] row_q;
	logic [DIM_W-1:0] w;
	logic [DIM_W-1:0] h;
	logic [STR_W-1:0] s;
	logic [CNT_W-1:0] w_m1;
	logic [CNT_W-1:0] h_m1;
	logic [CNT_W-1:0] x;
	logic [CNT_W-1:0] y;
	logic             row_end;

	// zero counts as one, oversize saturates
	always_comb begin
		if (cfg.width == '0) begin
			w = DIM_W'(1);
		end else if (32'(cfg.width) > MAX_DIM) begin
			w = DIM_W'(MAX_DIM);
		end else begin
			w = DIM_W'(cfg.width);
		end
		if (cfg.height == '0) begin
			h = DIM_W'(1);
		end else if (32'(cfg.height) > MAX_DIM) begin
			h = DIM_W'(MAX_DIM);
		end else begin
			h = DIM_W'(cfg.height);
		end
		if (cfg.stride == '0) begin
			s = STR_W'(1);
		end else if (32'(cfg.stride) > MAX_STRIDE) begin
			s = STR_W'(MAX_STRIDE);
		end else begin
			s = STR_W'(cfg.stride);
		end
	end

	assign w_m1    = CNT_W'(w - DIM_W'(1));
	assign h_m1    = CNT_W'(h - DIM_W'(1));
	assign x       = (column_q < w_m1) ? column_q : w_m1;
	assign y       = (row_q < h_m1) ? row_q : h_m1;
	assign row_end = (x == w_m1);

	always_comb begin
		pos.stride = s;
		pos.last   = row_end && (y == h_m1);
		unique case (cfg.rotation)
			ROT_0: begin
				pos.mul_a = y;
				pos.add_b = x;
			end
			ROT_90: begin
				pos.mul_a = x;
				pos.add_b = h_m1 - y;
			end
			ROT_180: begin
				pos.mul_a = h_m1 - y;
				pos.add_b = w_m1 - x;
			end
			ROT_270: begin
				pos.mul_a = w_m1 - x;
				pos.add_b = y;
			end
			default: begin
				pos.mul_a = y;
				pos.add_b = x;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (step) begin
			if (row_end) begin
				column_q <= '0;
				row_q    <= pos.last ? '0 : y + CNT_W'(1);
			end else begin
				column_q <= x + CNT_W'(1);
				row_q    <= y;
			end
		end
	end

`ifndef SYNTHESIS
	// after a step, with the settings held, the counters sit inside the region
	a_column_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		$past(step) && $stable(cfg) |-> (column_q <= w_m1) && (row_q <= h_m1))
		else $error("position counter left the active region");
`endif

endmodule

>>> rtl/core/ytr_csc.sv
// ----------------------------------------------------------------------------
// ytr_csc: bt.601 color conversion
// integer yuv to opaque argb, each channel clamped and taken from bits 17:10
// ----------------------------------------------------------------------------
module ytr_csc
	import ytr_pkg::*;
(
	input  logic [SAMPLE_W-1:0] luma,
	input  logic [SAMPLE_W-1:0] chroma_blue,
	input  logic [SAMPLE_W-1:0] chroma_red,
	output logic [PIXEL_W-1:0]  pixel_word
);

	logic signed [SAMPLE_W:0]  y_off;
	logic signed [SAMPLE_W:0]  u_off;
	logic signed [SAMPLE_W:0]  v_off;
	logic signed [SUM_W-1:0]   r_sum;
	logic signed [SUM_W-1:0]   g_sum;
	logic signed [SUM_W-1:0]   b_sum;
	logic        [SAMPLE_W-1:0] r_ch;
	logic        [SAMPLE_W-1:0] g_ch;
	logic        [SAMPLE_W-1:0] b_ch;

	function automatic logic [SAMPLE_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
		logic [SAMPLE_W-1:0] res;
		if (sum < 0) begin
			res = '0;
		end else if (32'(sum) > CLAMP_MAX) begin
			res = '1;
		end else begin
			res = sum[17:10];
		end
		return res;
	endfunction

	// luma below black level clamps to zero
	assign y_off = (luma < SAMPLE_W'(LUMA_OFFSET)) ? '0
		: $signed({1'b0, luma}) - (SAMPLE_W+1)'(LUMA_OFFSET);
	assign u_off = $signed({1'b0, chroma_blue}) - (SAMPLE_W+1)'(CHROMA_OFFSET);
	assign v_off = $signed({1'b0, chroma_red}) - (SAMPLE_W+1)'(CHROMA_OFFSET);

	assign r_sum = SUM_W'(COEF_Y * int'(y_off) + COEF_RV * int'(v_off));
	assign g_sum = SUM_W'(COEF_Y * int'(y_off) - COEF_GV * int'(v_off)
		- COEF_GU * int'(u_off));
	assign b_sum = SUM_W'(COEF_Y * int'(y_off) + COEF_BU * int'(u_off));

	assign r_ch = clamp_channel(r_sum);
	assign g_ch = clamp_channel(g_sum);
	assign b_ch = clamp_channel(b_sum);

	assign pixel_word = {ALPHA_OPAQUE, r_ch, g_ch, b_ch};

endmodule

>>> tb/ytr_argb_scoreboard.sv
// ----------------------------------------------------------------------------
// ytr_argb_scoreboard: argb word and destination index checker
// watches the register port and both pixel channels, predicts each output
// word from the accepted yuv word and compares it with what the block gives
// ----------------------------------------------------------------------------
module ytr_argb_scoreboard
	import ytr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ytr_in_if                     pixel_in,
	ytr_out_if                    pixel_out,
	output int                    failures,
	output int                    words_pending
);

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel_word;
		logic [INDEX_W-1:0] dest_index;
		logic               frame_end;
	} dest_word_t;

	// shadow registers and source position
	rot_t rotation;
	int   width_reg;
	int   height_reg;
	int   stride_reg;
	int   column_pos;
	int   row_pos;
	int   fail_total;

	dest_word_t expected_words[$];

	function automatic int fit_to(int value, int top);
		if (value == 0)
			return 1;
		return (value > top) ? top : value;
	endfunction

	function automatic logic [SAMPLE_W-1:0] clamp_channel(int sum);
		if (sum < 0)
			sum = 0;
		if (sum > CLAMP_MAX)
			sum = CLAMP_MAX;
		return SAMPLE_W'(sum >> 10);
	endfunction

	function automatic logic [PIXEL_W-1:0] yuv_to_argb(logic [SAMPLE_W-1:0] y8,
		logic [SAMPLE_W-1:0] u8, logic [SAMPLE_W-1:0] v8);
		int y;
		int u;
		int v;
		y = int'(y8) - LUMA_OFFSET;
		if (y < 0)
			y = 0;
		u = int'(u8) - CHROMA_OFFSET;
		v = int'(v8) - CHROMA_OFFSET;
		return {ALPHA_OPAQUE,
			clamp_channel(COEF_Y * y + COEF_RV * v),
			clamp_channel(COEF_Y * y - COEF_GV * v - COEF_GU * u),
			clamp_channel(COEF_Y * y + COEF_BU * u)};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int         w;
		int         h;
		int         s;
		int         x;
		int         y;
		longint     offset;
		dest_word_t got;
		dest_word_t want;
		if (!arst_n) begin
			rotation   = ROT_0;
			width_reg  = int'(WIDTH_RESET);
			height_reg = int'(HEIGHT_RESET);
			stride_reg = int'(STRIDE_RESET);
			column_pos = 0;
			row_pos    = 0;
			fail_total = 0;
			expected_words.delete();
			failures      <= 0;
			words_pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_ROTATION: rotation   = rot_t'(cfg_data[ROT_W-1:0]);
					REG_WIDTH:    width_reg  = int'(cfg_data[WIDTH_REG_W-1:0]);
					REG_HEIGHT:   height_reg = int'(cfg_data[HEIGHT_REG_W-1:0]);
					REG_STRIDE:   stride_reg = int'(cfg_data[STRIDE_REG_W-1:0]);
					default: ;
				endcase
			end

			if (pixel_out.valid && pixel_out.ready) begin
				got = {pixel_out.pixel_word, pixel_out.dest_index, pixel_out.frame_end};
				if (expected_words.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("unexpected word: argb %h index %0d end %b",
							got.pixel_word, got.dest_index, got.frame_end);
				end else begin
					want = expected_words.pop_front();
					if (got.pixel_word !== want.pixel_word
						|| got.dest_index !== want.dest_index
						|| got.frame_end !== want.frame_end) begin
						fail_total++;
						if (fail_total <= 10)
							$display({"mismatch: expected argb %h index %0d end %b,",
								" got argb %h index %0d end %b"},
								want.pixel_word, want.dest_index, want.frame_end,
								got.pixel_word, got.dest_index, got.frame_end);
					end
				end
			end

			if (pixel_in.valid && pixel_in.ready) begin
				w = fit_to(width_reg, MAX_DIM);
				h = fit_to(height_reg, MAX_DIM);
				s = fit_to(stride_reg, MAX_STRIDE);
				// counters left past a shrunk region are pulled back inside it
				x = (column_pos < w - 1) ? column_pos : w - 1;
				y = (row_pos < h - 1) ? row_pos : h - 1;
				case (rotation)
					ROT_0:   offset = longint'(y) * s + x;
					ROT_90:  offset = longint'(x) * s + (h - 1 - y);
					ROT_180: offset = longint'(h - 1 - y) * s + (w - 1 - x);
					default: offset = longint'(w - 1 - x) * s + y;
				endcase
				want.pixel_word = yuv_to_argb(pixel_in.luma, pixel_in.chroma_blue,
					pixel_in.chroma_red);
				want.dest_index = offset[INDEX_W-1:0];
				want.frame_end  = (x == w - 1) && (y == h - 1);
				if (x == w - 1) begin
					column_pos = 0;
					row_pos    = want.frame_end ? 0 : y + 1;
				end else begin
					column_pos = x + 1;
					row_pos    = y;
				end
				expected_words.push_back(want);
			end

			failures      <= fail_total;
			words_pending <= expected_words.size();
		end
	end

endmodule

>>> tb/yuv_to_rgba_rotating_writer_top_tb.sv
// ----------------------------------------------------------------------------
// yuv_to_rgba_rotating_writer_top_tb: testbench for the rotating argb writer
// drives yuv words and register settings, with random gaps on the input and
// random stalls on the output; the scoreboard beside the block checks every
// argb word, destination index and frame end flag
// ----------------------------------------------------------------------------
module yuv_to_rgba_rotating_writer_top_tb
	import ytr_pkg::*;
();

	localparam int PIXEL_TARGET = 1500;
	localparam int CYCLE_LIMIT  = 200000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int word_failures;
	int words_pending;
	int pixels_sent;
	int cycle_count;
	bit steady_flow;   // no idling on either side while set

	ytr_in_if  pixel_in ();
	ytr_out_if pixel_out ();

	yuv_to_rgba_rotating_writer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel_in  (pixel_in),
		.pixel_out (pixel_out)
	);

	ytr_argb_scoreboard u_argb_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pixel_in      (pixel_in),
		.pixel_out     (pixel_out),
		.failures      (word_failures),
		.words_pending (words_pending)
	);

	// 8 unit clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// output side drops ready with a chance of 30 in 100 unless steady flow is set
	always @(posedge clk) begin
		pixel_out.ready <= steady_flow || ($urandom_range(0, 99) >= 30);
	end

	// run guard
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// offer one yuv word, after a random gap, and hold it until taken
	task automatic send_pixel(logic [SAMPLE_W-1:0] y, logic [SAMPLE_W-1:0] u,
		logic [SAMPLE_W-1:0] v);
		while (!steady_flow && $urandom_range(0, 99) < 30) begin
			pixel_in.valid <= 1'b0;
			@(posedge clk);
		end
		pixel_in.valid       <= 1'b1;
		pixel_in.luma        <= y;
		pixel_in.chroma_blue <= u;
		pixel_in.chroma_red  <= v;
		@(posedge clk);
		while (!pixel_in.ready)
			@(posedge clk);
		pixels_sent++;
	endtask

	// mostly uniform samples, now and then the clamp and offset corners
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 11))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'(LUMA_OFFSET);
			3:       return 8'(CHROMA_OFFSET);
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random_pixel();
		send_pixel(pick_sample(), pick_sample(), pick_sample());
	endtask

	// stop feeding and wait until every predicted word has come out
	task automatic drain_pipeline();
		pixel_in.valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t index, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
	endtask

	// registers change only with the pipeline empty; counters carry over
	task automatic program_regs(logic [CFG_DATA_W-1:0] rotation,
		logic [CFG_DATA_W-1:0] width, logic [CFG_DATA_W-1:0] height,
		logic [CFG_DATA_W-1:0] stride);
		drain_pipeline();
		write_reg(REG_ROTATION, rotation);
		write_reg(REG_WIDTH, width);
		write_reg(REG_HEIGHT, height);
		write_reg(REG_STRIDE, stride);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// small frames so frame ends come often; sometimes full-range data,
	// which also exercises masking and saturation
	task automatic program_random_regs();
		if ($urandom_range(0, 7) == 0)
			program_regs(CFG_DATA_W'($urandom_range(0, 16383)),
				CFG_DATA_W'($urandom_range(0, 16383)),
				CFG_DATA_W'($urandom_range(0, 16383)),
				CFG_DATA_W'($urandom_range(0, 16383)));
		else
			program_regs(CFG_DATA_W'($urandom_range(0, 3)),
				CFG_DATA_W'($urandom_range(0, 9)),
				CFG_DATA_W'($urandom_range(0, 9)),
				CFG_DATA_W'($urandom_range(0, 24)));
	endtask

	initial begin
		int phase;
		int burst;

		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_ROTATION;
		cfg_data             = '0;
		pixel_in.valid       = 1'b0;
		pixel_in.luma        = '0;
		pixel_in.chroma_blue = '0;
		pixel_in.chroma_red  = '0;
		steady_flow          = 1'b0;
		pixels_sent          = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: black, white, luma below offset, color clamps
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd16, 8'd128, 8'd128);
		send_pixel(8'd15, 8'd128, 8'd128);
		send_pixel(8'd235, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);

		// rotate 90 into a 3 x 2 frame while the column sits past it,
		// zero stride counts as one; runs through a frame end
		program_regs(CFG_DATA_W'(ROT_90), 14'd3, 14'd2, 14'd0);
		repeat (6) send_random_pixel();

		// zero width and height give a single pixel frame, stride saturates
		program_regs(CFG_DATA_W'(ROT_0), 14'd0, 14'd0, 14'd16383);
		repeat (2) send_random_pixel();

		// oversized dimensions saturate at the maximum
		program_regs(CFG_DATA_W'(ROT_270), 14'd8191, 14'd8191, 14'd8192);
		repeat (3) send_random_pixel();

		// largest frame and stride under 180 degree rotation, writing near the far corner
		program_regs(CFG_DATA_W'(ROT_180), 14'd4096, 14'd4096, 14'd8192);
		repeat (2) send_random_pixel();

		// random settings and bursts, with a stretch of steady flow
		phase = 0;
		while (pixels_sent < PIXEL_TARGET) begin
			steady_flow = (phase >= 10) && (phase < 15);
			program_random_regs();
			burst = $urandom_range(20, 80);
			repeat (burst) send_random_pixel();
			phase++;
		end
		steady_flow = 1'b0;

		drain_pipeline();
		if (word_failures == 0 && words_pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
